// ===== hw/rtl/rpn_stack_evaluator_unit_macros.svh =====
// Assertion helpers for the evaluator's top-level RTL file.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RPN_STACK_EVALUATOR_UNIT_MACROS_SVH
`define RPN_STACK_EVALUATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpn check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpn check failed");

`endif

// ===== hw/rtl/rpn_pkg.sv =====
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FUNC_W          = 4;
  localparam int unsigned STATUS_W        = 4;
  localparam int unsigned DEPTH_W         = 8;
  localparam int unsigned IO_VALUE_W      = 32;

  // Token codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_NUMBER = 4'd0,
    FN_ADD    = 4'd1,
    FN_SUB    = 4'd2,
    FN_MUL    = 4'd3,
    FN_DIV    = 4'd4,
    FN_MOD    = 4'd5,
    FN_EOL    = 4'd6,
    FN_PEEK   = 4'd7,
    FN_DUP    = 4'd8,
    FN_SWAP   = 4'd9,
    FN_CLEAR  = 4'd10
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 4'd0,
    ST_LINE    = 4'd1,
    ST_PEEK    = 4'd2,
    ST_DUP     = 4'd3,
    ST_SWAP    = 4'd4,
    ST_CLEAR   = 4'd5,
    ST_EMPTY   = 4'd6,
    ST_FULL    = 4'd7,
    ST_ZDIV    = 4'd8,
    ST_UNKNOWN = 4'd9,
    ST_ALREADY = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_MOD,
    ALU_PASS
  } alu_op_e;

  typedef enum logic [1:0] {
    TOS_KEEP,
    TOS_NUM,
    TOS_RES,
    TOS_NOS
  } tos_sel_e;

  typedef enum logic [1:0] {
    WD_NUM,
    WD_RES,
    WD_TOS,
    WD_NOS
  } wd_sel_e;

  typedef enum logic [1:0] {
    REP_TOS,
    REP_ZERO,
    REP_RES
  } rep_sel_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic     cap_num;
    logic     cap_nos;
    logic     start;
    logic     have_a;
    logic     have_b;
    logic     out_load;
    alu_op_e  alu_op;
    tos_sel_e tos_sel;
    wd_sel_e  wd_sel;
    rep_sel_e rep_sel;
  } dp_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic done;
    logic b_zero;
    logic b_int_zero;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rpn_in_if.sv =====
interface rpn_in_if import rpn_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [FUNC_W-1:0]            func;
  logic signed [IO_VALUE_W-1:0] number;

  modport source (output valid, output func, output number, input ready);
  modport sink (input valid, input func, input number, output ready);
endinterface

// ===== hw/rtl/rpn_out_if.sv =====
interface rpn_out_if import rpn_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic signed [IO_VALUE_W-1:0] value;
  logic [DEPTH_W-1:0]           depth;

  modport source (output valid, output status, output value, output depth, input ready);
  modport sink (input valid, input status, input value, input depth, output ready);
endinterface

// ===== hw/rtl/rpn_ram.sv =====
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rpn_dp.sv =====
module rpn_dp import rpn_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [IO_VALUE_W-1:0] in_number_i,
  input  dp_cmd_t                      cmd_i,
  output dp_stat_t                     stat_o,
  output logic [VALUE_WIDTH-1:0]       ram_wdata_o,
  input  logic [VALUE_WIDTH-1:0]       ram_rdata_i,
  output logic signed [IO_VALUE_W-1:0] out_value_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = VALUE_WIDTH / 2;
  localparam int unsigned NW = W + F;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [W-1:0] SIGN   = W'(1) << (W - 1);
  localparam logic [W-1:0] POSMAX = SIGN - W'(1);
  localparam logic signed [63:0] VMAX = $signed(64'h7FFF_FFFF_FFFF_FFFF >> (64 - W));
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic signed [63:0] OMAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] OMIN = 64'shFFFF_FFFF_8000_0000;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    logic [W-1:0] t;
    t = ~x;
    return x[W-1] ? t + W'(1) : x;
  endfunction

  function automatic logic [W-1:0] from_mag(input logic neg, input logic [W-1:0] m,
                                            input logic over);
    logic [W-1:0] lim;
    logic [W-1:0] m2;
    lim = neg ? SIGN : POSMAX;
    m2  = (over || (m > lim)) ? lim : m;
    return neg ? (~m2) + W'(1) : m2;
  endfunction

  logic [W-1:0]       num_q, nos_q, tos_q, res_q;
  logic [W-1:0]       ma_q, mb_q;
  logic               neg_q;
  logic [2*W-1:0]     prod_q;
  logic [W:0]         rem_q;
  logic [NW-1:0]      quo_q;
  logic signed [IO_VALUE_W-1:0] out_value_q;
  logic               busy_q, done_q;
  logic [CW-1:0]      cnt_q;
  alu_op_e            op_q;

  logic signed [63:0] num_ext, rep_ext;
  logic [W-1:0]       num_sat, opa, opb, ma, mb, rep;
  logic [W-1:0]       sum, dif, res_d;
  logic [2*W-1:0]     prod_d;
  logic [W:0]         trial, rem_d;
  logic               ge;
  logic [NW-1:0]      quo_d;

  assign num_ext = 64'(in_number_i);
  assign num_sat = (num_ext > VMAX) ? VMAX[W-1:0] :
                   (num_ext < VMIN) ? VMIN[W-1:0] : num_ext[W-1:0];

  assign opa = cmd_i.have_a ? nos_q : '0;
  assign opb = cmd_i.have_b ? tos_q : '0;
  assign ma  = mag(opa);
  assign mb  = mag(opb);
  assign sum = opa + opb;
  assign dif = opa - opb;

  assign stat_o.done       = done_q;
  assign stat_o.b_zero     = (opb == '0);
  assign stat_o.b_int_zero = ((mb >> F) == '0);

  // One shift-add step of the multiplier and one restoring step of the divider.
  assign prod_d = {prod_q[2*W-2:0], 1'b0} + (mb_q[W-1] ? (2*W)'(ma_q) : '0);
  assign trial  = {rem_q[W-1:0], quo_q[NW-1]};
  assign ge     = (trial >= {1'b0, mb_q});
  assign rem_d  = ge ? trial - {1'b0, mb_q} : trial;
  assign quo_d  = {quo_q[NW-2:0], ge};

  always_comb begin
    case (op_q)
      ALU_MUL: res_d = from_mag(neg_q, prod_d[F +: W], |prod_d[2*W-1:F+W]);
      ALU_DIV: res_d = from_mag(neg_q, quo_d[W-1:0], |quo_d[NW-1:W]);
      ALU_MOD: res_d = from_mag(neg_q, W'(rem_d[W-1:0] << F), 1'b0);
      default: res_d = res_q;
    endcase
  end

  always_comb begin
    case (cmd_i.rep_sel)
      REP_TOS: rep = tos_q;
      REP_RES: rep = res_q;
      default: rep = '0;
    endcase
  end
  assign rep_ext = 64'($signed(rep));

  always_comb begin
    case (cmd_i.wd_sel)
      WD_NUM:  ram_wdata_o = num_q;
      WD_RES:  ram_wdata_o = res_q;
      WD_TOS:  ram_wdata_o = tos_q;
      default: ram_wdata_o = nos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_PASS;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        op_q <= cmd_i.alu_op;
        case (cmd_i.alu_op)
          ALU_MUL: begin
            busy_q <= 1'b1;
            cnt_q  <= CW'(W - 1);
          end
          ALU_DIV, ALU_MOD: begin
            busy_q <= 1'b1;
            cnt_q  <= CW'(NW - 1);
          end
          default: done_q <= 1'b1;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_num) begin
      num_q <= num_sat;
    end
    if (cmd_i.cap_nos) begin
      nos_q <= ram_rdata_i;
    end
    case (cmd_i.tos_sel)
      TOS_NUM: tos_q <= num_q;
      TOS_RES: tos_q <= res_q;
      TOS_NOS: tos_q <= nos_q;
      default: tos_q <= tos_q;
    endcase
    if (cmd_i.out_load) begin
      out_value_q <= (rep_ext > OMAX) ? OMAX[IO_VALUE_W-1:0] :
                     (rep_ext < OMIN) ? OMIN[IO_VALUE_W-1:0] : rep_ext[IO_VALUE_W-1:0];
    end
    if (cmd_i.start) begin
      ma_q   <= ma;
      prod_q <= '0;
      rem_q  <= '0;
      case (cmd_i.alu_op)
        ALU_ADD: res_q <= (opa[W-1] == opb[W-1] && sum[W-1] != opa[W-1]) ?
                          (opa[W-1] ? SIGN : POSMAX) : sum;
        ALU_SUB: res_q <= (opa[W-1] != opb[W-1] && dif[W-1] != opa[W-1]) ?
                          (opa[W-1] ? SIGN : POSMAX) : dif;
        ALU_MUL: begin
          mb_q  <= mb;
          neg_q <= opa[W-1] ^ opb[W-1];
        end
        ALU_DIV: begin
          mb_q  <= mb;
          neg_q <= opa[W-1] ^ opb[W-1];
          quo_q <= {ma, F'(0)};
        end
        ALU_MOD: begin
          mb_q  <= mb >> F;
          neg_q <= opa[W-1];
          quo_q <= NW'(ma >> F);
        end
        default: res_q <= opb;
      endcase
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        prod_q <= prod_d;
        mb_q   <= mb_q << 1;
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      if (cnt_q == '0) begin
        res_q <= res_d;
      end
    end
  end

  assign out_value_o = out_value_q;

endmodule

// ===== hw/rtl/rpn_ctrl.sv =====
module rpn_ctrl import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   in_func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [DEPTH_W-1:0]  out_depth_o,
  output dp_cmd_t             cmd_o,
  input  dp_stat_t            stat_i,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_addr_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_SWAP2,
    S_WAIT,
    S_FIN,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [SPW-1:0]      sp_q, sp_d;
  logic                after_q, after_d;
  logic                line_q, line_d;
  status_e             stat_q, stat_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [DEPTH_W-1:0]  out_depth_q, out_depth_d;

  logic                sp_ge1, sp_ge2, sp_full, needs_nos;
  logic [SPW+7:0]      sp_ext;
  logic [AW-1:0]       addr_top, addr_next, addr_second;

  assign sp_ge1      = (sp_q != '0);
  assign sp_ge2      = (sp_q > SPW'(1));
  assign sp_full     = (sp_q == SPW'(STACK_DEPTH));
  assign addr_top    = AW'(sp_q - SPW'(1));
  assign addr_next   = AW'(sp_q);
  assign addr_second = AW'(sp_q - SPW'(2));
  assign sp_ext      = (SPW + 8)'(sp_q);

  always_comb begin
    case (func_q)
      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_SWAP: needs_nos = sp_ge2;
      FN_EOL:  needs_nos = sp_ge2 && !after_q;
      default: needs_nos = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    sp_d         = sp_q;
    after_d      = after_q;
    line_d       = line_q;
    stat_d       = stat_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_depth_d  = out_depth_q;
    in_ready_o   = 1'b0;
    ram_we_o     = 1'b0;
    ram_addr_o   = addr_second;
    cmd_o.cap_num  = 1'b0;
    cmd_o.cap_nos  = 1'b0;
    cmd_o.start    = 1'b0;
    cmd_o.have_a   = 1'b0;
    cmd_o.have_b   = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.alu_op   = ALU_PASS;
    cmd_o.tos_sel  = TOS_KEEP;
    cmd_o.wd_sel   = WD_RES;
    cmd_o.rep_sel  = REP_ZERO;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d        = in_func_i;
          cmd_o.cap_num = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = needs_nos ? S_READ : S_EXEC;
      end
      S_READ: begin
        cmd_o.cap_nos = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        after_d = 1'b0;
        line_d  = 1'b0;
        state_d = S_RESP;
        case (func_q)
          FN_NUMBER: begin
            if (sp_full) begin
              stat_d = ST_FULL;
            end else begin
              ram_we_o      = 1'b1;
              ram_addr_o    = addr_next;
              cmd_o.wd_sel  = WD_NUM;
              cmd_o.tos_sel = TOS_NUM;
              sp_d          = sp_q + SPW'(1);
              stat_d        = ST_DONE;
            end
          end
          FN_ADD, FN_SUB, FN_MUL: begin
            cmd_o.start  = 1'b1;
            cmd_o.have_a = sp_ge2;
            cmd_o.have_b = sp_ge1;
            cmd_o.alu_op = (func_q == FN_ADD) ? ALU_ADD :
                           (func_q == FN_SUB) ? ALU_SUB : ALU_MUL;
            state_d      = S_WAIT;
          end
          FN_DIV, FN_MOD: begin
            cmd_o.have_b = sp_ge1;
            if ((func_q == FN_DIV) ? stat_i.b_zero : stat_i.b_int_zero) begin
              // The divisor is consumed and the dividend becomes the top.
              stat_d        = ST_ZDIV;
              sp_d          = sp_ge1 ? sp_q - SPW'(1) : '0;
              cmd_o.tos_sel = TOS_NOS;
            end else begin
              cmd_o.start  = 1'b1;
              cmd_o.have_a = sp_ge2;
              cmd_o.alu_op = (func_q == FN_DIV) ? ALU_DIV : ALU_MOD;
              state_d      = S_WAIT;
            end
          end
          FN_EOL: begin
            if (after_q) begin
              stat_d = ST_DONE;
            end else begin
              cmd_o.start  = 1'b1;
              cmd_o.have_b = sp_ge1;
              cmd_o.alu_op = ALU_PASS;
              state_d      = S_WAIT;
            end
          end
          FN_PEEK: begin
            after_d = 1'b1;
            stat_d  = sp_ge1 ? ST_PEEK : ST_EMPTY;
          end
          FN_DUP: begin
            after_d = 1'b1;
            if (!sp_ge1) begin
              stat_d = ST_EMPTY;
            end else if (sp_full) begin
              stat_d = ST_FULL;
            end else begin
              ram_we_o     = 1'b1;
              ram_addr_o   = addr_next;
              cmd_o.wd_sel = WD_TOS;
              sp_d         = sp_q + SPW'(1);
              stat_d       = ST_DUP;
            end
          end
          FN_SWAP: begin
            after_d = 1'b1;
            if (sp_ge2) begin
              ram_we_o     = 1'b1;
              ram_addr_o   = addr_second;
              cmd_o.wd_sel = WD_TOS;
              stat_d       = ST_SWAP;
              state_d      = S_SWAP2;
            end else begin
              stat_d = ST_EMPTY;
            end
          end
          FN_CLEAR: begin
            after_d = 1'b1;
            if (sp_ge1) begin
              sp_d   = '0;
              stat_d = ST_CLEAR;
            end else begin
              stat_d = ST_ALREADY;
            end
          end
          default: begin
            stat_d = ST_UNKNOWN;
          end
        endcase
      end
      S_SWAP2: begin
        ram_we_o      = 1'b1;
        ram_addr_o    = addr_top;
        cmd_o.wd_sel  = WD_NOS;
        cmd_o.tos_sel = TOS_NOS;
        state_d       = S_RESP;
      end
      S_WAIT: begin
        if (stat_i.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_RESP;
        if (func_q == FN_EOL) begin
          line_d        = 1'b1;
          stat_d        = sp_ge1 ? ST_LINE : ST_EMPTY;
          sp_d          = sp_ge1 ? sp_q - SPW'(1) : '0;
          cmd_o.tos_sel = TOS_NOS;
        end else begin
          // With two operands, both are popped and one result pushed; else the result is the only entry.
          ram_we_o      = 1'b1;
          ram_addr_o    = sp_ge2 ? addr_second : '0;
          cmd_o.wd_sel  = WD_RES;
          cmd_o.tos_sel = TOS_RES;
          sp_d          = sp_ge2 ? sp_q - SPW'(1) : SPW'(1);
          stat_d        = sp_ge2 ? ST_DONE : ST_EMPTY;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_status_d   = stat_q;
          out_depth_d    = (sp_ext > (SPW + 8)'(255)) ? 8'hFF : sp_ext[7:0];
          cmd_o.out_load = 1'b1;
          cmd_o.rep_sel  = line_q ? REP_RES : (sp_ge1 ? REP_TOS : REP_ZERO);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= '0;
      sp_q         <= '0;
      after_q      <= 1'b0;
      line_q       <= 1'b0;
      stat_q       <= ST_DONE;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_depth_q  <= '0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      sp_q         <= sp_d;
      after_q      <= after_d;
      line_q       <= line_d;
      stat_q       <= stat_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_depth_q  <= out_depth_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_depth_o  = out_depth_q;

endmodule

// ===== hw/rtl/rpn_stack_evaluator_unit.sv =====
// A token goes through decode, a read of the second entry where one is needed, execution
// (a second write for swap, a wait on the arithmetic unit for add, sub, mul, end of line and
// div and mod unless the divisor is zero, one divider step per cycle) and the result beat.
// Tokens are taken one at a time; the next token is taken as soon as the result sits in
// the output register, so the shift-add multiplier and restoring divider set the worst case.
// Reset (asynchronous, active low) empties the stack; stack memory contents are not cleared.
`include "rpn_stack_evaluator_unit_macros.svh"

module rpn_stack_evaluator_unit import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  rpn_in_if.sink     in_i,
  rpn_out_if.source  out_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // The sequencer owns the stack pointer, the end-of-line flag and the result
  // beat's status and depth; the datapath owns the cached top of stack, the
  // second entry read from memory, and the iterative arithmetic unit. The
  // memory holds every entry, including a copy of the top.
  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [VALUE_WIDTH-1:0]   ram_wdata;
  logic [VALUE_WIDTH-1:0]   ram_rdata;

  rpn_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (in_i.func),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_status_o(out_o.status),
    .out_depth_o (out_o.depth),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr)
  );

  rpn_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_number_i(in_i.number),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata),
    .out_value_o(out_o.value)
  );

  // Stack storage: one write and one read port share the sequencer's address.
  rpn_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // A token is worked on alone: after an input beat the port stays closed.
  `RPN_ASSERT_NEXT(a_one_token, in_i.valid && in_i.ready, !in_i.ready)
  // A full stack can only be reported at the configured depth, capped at 255.
  `RPN_ASSERT_SAME(a_full_depth, out_o.valid && out_o.status == ST_FULL,
                   out_o.depth == DEPTH_W'((STACK_DEPTH > 255) ? 255 : STACK_DEPTH))
  // After a clear, cleared or not, the stack is empty.
  `RPN_ASSERT_SAME(a_clear_depth,
                   out_o.valid && (out_o.status == ST_CLEAR || out_o.status == ST_ALREADY),
                   out_o.depth == '0)
  // A result beat never reports more entries than the stack holds.
  `RPN_ASSERT_SAME(a_depth_bound, out_o.valid, 32'(out_o.depth) <= STACK_DEPTH)

endmodule
